>>> design/bom_sniffing_utf16le_to_utf8_assert.svh
// Assertion macros shared by the checker of the BOM-sniffing transcoder.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef BOM_SNIFFING_UTF16LE_TO_UTF8_ASSERT_SVH
`define BOM_SNIFFING_UTF16LE_TO_UTF8_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bsu_pkg.sv
// Shared types, constants and UTF-8 encode helpers for the transcoder.
// Used by the front, queue and back modules; depends on nothing.
package bsu_pkg;

    // Byte-order-mark bytes
    localparam logic [7:0] BOM16_B0 = 8'hFF;
    localparam logic [7:0] BOM16_B1 = 8'hFE;
    localparam logic [7:0] BOM8_B0  = 8'hEF;
    localparam logic [7:0] BOM8_B1  = 8'hBB;
    localparam logic [7:0] BOM8_B2  = 8'hBF;

    // Surrogate classes by the top six bits of a unit
    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    localparam int QUEUE_DEPTH = 2;

    // One classified item: either raw bytes or up to two code points
    typedef struct packed {
        logic        is_raw;
        logic [1:0]  raw_cnt;
        logic [7:0]  raw0;
        logic [7:0]  raw1;
        logic [7:0]  raw2;
        logic        cp0_v;
        logic [20:0] cp0;
        logic        cp1_v;
        logic [20:0] cp1;
        logic        fin;
    } bsu_job_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } bsu_qstat_t;

    // UTF-8 length of a code point
    function automatic logic [2:0] cp_len(logic [20:0] cp);
        logic [2:0] len;
        if (cp <= 21'h7F)
            len = 3'd1;
        else if (cp <= 21'h7FF)
            len = 3'd2;
        else if (cp <= 21'hFFFF)
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

    // Byte j of the UTF-8 form of cp, whose length is len
    function automatic logic [7:0] enc_byte(logic [20:0] cp, logic [2:0] len,
                                            logic [2:0] j);
        logic [7:0] b;
        b = 8'h00;
        unique case (len)
            3'd1: b = cp[7:0];
            3'd2: b = (j == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            3'd3:
            begin
                unique case (j)
                    3'd0:    b = {4'b1110, cp[15:12]};
                    3'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                unique case (j)
                    3'd0:    b = {5'b11110, cp[20:18]};
                    3'd1:    b = {2'b10, cp[17:12]};
                    3'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

>>> design/bsu_front.sv
// Front: accepts input bytes, sniffs the mark, pairs UTF-16LE units and
// joins surrogates into jobs for the queue. Depends on bsu_pkg.
module bsu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              final_byte,
    input  bsu_pkg::bsu_qstat_t qstat,
    output logic              push,
    output bsu_pkg::bsu_job_t job
);
    import bsu_pkg::*;

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_FF    = 6'b000010,
        PH_EF    = 6'b000100,
        PH_EFBB  = 6'b001000,
        PH_PASS  = 6'b010000,
        PH_U16   = 6'b100000
    } bsu_phase_t;

    bsu_phase_t  phase_reg, phase_next;
    logic [7:0]  low_reg, low_next;
    logic        low_v_reg, low_v_next;
    logic [15:0] high_reg, high_next;
    logic        high_v_reg, high_v_next;

    logic        accept;
    logic [15:0] unit;
    logic [20:0] joined;
    logic        nonempty;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;
    assign unit     = {in_byte, low_reg};
    assign joined   = SUPP_BASE + {1'b0, high_reg[9:0], unit[9:0]};

    // Classify the byte and work out the next sniffing state
    always_comb
    begin
        phase_next  = phase_reg;
        low_next    = low_reg;
        low_v_next  = low_v_reg;
        high_next   = high_reg;
        high_v_next = high_v_reg;
        job         = '0;
        job.fin     = final_byte;
        job.raw0    = in_byte;
        unique case (phase_reg)
            PH_START:
            begin
                if (!final_byte && in_byte == BOM16_B0)
                    phase_next = PH_FF;
                else if (!final_byte && in_byte == BOM8_B0)
                    phase_next = PH_EF;
                else
                begin
                    job.is_raw  = 1'b1;
                    job.raw_cnt = 2'd1;
                    phase_next  = PH_PASS;
                end
            end
            PH_FF:
            begin
                if (in_byte == BOM16_B1)
                    phase_next = PH_U16;
                else
                begin
                    job.is_raw  = 1'b1;
                    job.raw_cnt = 2'd2;
                    job.raw0    = BOM16_B0;
                    job.raw1    = in_byte;
                    phase_next  = PH_PASS;
                end
            end
            PH_EF:
            begin
                if (in_byte == BOM8_B1 && !final_byte)
                    phase_next = PH_EFBB;
                else
                begin
                    job.is_raw  = 1'b1;
                    job.raw_cnt = 2'd2;
                    job.raw0    = BOM8_B0;
                    job.raw1    = in_byte;
                    phase_next  = PH_PASS;
                end
            end
            PH_EFBB:
            begin
                if (in_byte != BOM8_B2)
                begin
                    job.is_raw  = 1'b1;
                    job.raw_cnt = 2'd3;
                    job.raw0    = BOM8_B0;
                    job.raw1    = BOM8_B1;
                    job.raw2    = in_byte;
                end
                phase_next = PH_PASS;
            end
            PH_PASS:
            begin
                job.is_raw  = 1'b1;
                job.raw_cnt = 2'd1;
            end
            default:
            begin
                // UTF-16LE: first byte of a unit is held, second completes it
                if (!low_v_reg)
                begin
                    low_next   = in_byte;
                    low_v_next = 1'b1;
                    if (final_byte && high_v_reg)
                    begin
                        job.cp0_v   = 1'b1;
                        job.cp0     = {5'd0, high_reg};
                        high_v_next = 1'b0;
                    end
                end
                else
                begin
                    low_v_next = 1'b0;
                    if (high_v_reg && unit[15:10] == SURR_LOW)
                    begin
                        job.cp0_v   = 1'b1;
                        job.cp0     = joined;
                        high_v_next = 1'b0;
                    end
                    else
                    begin
                        // unpaired high surrogate goes out on its own
                        job.cp0_v   = high_v_reg;
                        job.cp0     = {5'd0, high_reg};
                        high_v_next = 1'b0;
                        if (unit[15:10] == SURR_HIGH && !final_byte)
                        begin
                            high_next   = unit;
                            high_v_next = 1'b1;
                        end
                        else
                        begin
                            job.cp1_v = 1'b1;
                            job.cp1   = {5'd0, unit};
                        end
                    end
                end
            end
        endcase
        // end of text returns to start
        if (final_byte)
        begin
            phase_next  = PH_START;
            low_next    = 8'd0;
            low_v_next  = 1'b0;
            high_next   = 16'd0;
            high_v_next = 1'b0;
        end
    end

    // A job goes to the queue if it has bytes or ends the text
    assign nonempty = job.is_raw ? (job.raw_cnt != 2'd0) : (job.cp0_v || job.cp1_v);
    assign push     = accept && (nonempty || final_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            low_reg    <= 8'd0;
            low_v_reg  <= 1'b0;
            high_reg   <= 16'd0;
            high_v_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            low_reg    <= low_next;
            low_v_reg  <= low_v_next;
            high_reg   <= high_next;
            high_v_reg <= high_v_next;
        end
    end

endmodule

>>> design/bsu_queue.sv
// Two-entry job queue between the front and the back.
// Depends on bsu_pkg.
module bsu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bsu_pkg::bsu_job_t   push_job,
    input  logic                pop,
    output bsu_pkg::bsu_job_t   head_job,
    output bsu_pkg::bsu_qstat_t qstat
);
    import bsu_pkg::*;

    bsu_job_t   mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign qstat.full  = (count_reg == 2'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == 2'd0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_job    = mem_reg[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

>>> design/bsu_back.sv
// Back: walks the head job one output byte a cycle, while the output is not stalled, into the output register.
// Depends on bsu_pkg.
module bsu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bsu_pkg::bsu_job_t   head_job,
    input  bsu_pkg::bsu_qstat_t qstat,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                run_last,
    output logic                text_end
);
    import bsu_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       bvalid_reg, bvalid_next;
    logic       last_reg, last_next;
    logic       end_reg, end_next;

    logic [2:0] len0, len1, total;
    logic       load, is_last;

    // Byte count of the head job
    always_comb
    begin
        len0  = head_job.cp0_v ? cp_len(head_job.cp0) : 3'd0;
        len1  = head_job.cp1_v ? cp_len(head_job.cp1) : 3'd0;
        total = head_job.is_raw ? {1'b0, head_job.raw_cnt} : (len0 + len1);
    end

    assign load    = !qstat.empty && (!out_valid_reg || out_ready);
    assign is_last = (total == 3'd0) || (idx_reg == total - 3'd1);
    assign pop     = load && is_last;

    // Select the byte at the current position
    always_comb
    begin
        byte_next   = 8'd0;
        bvalid_next = (total != 3'd0);
        last_next   = is_last;
        end_next    = is_last && head_job.fin;
        if (total == 3'd0)
            byte_next = 8'd0;
        else if (head_job.is_raw)
        begin
            unique case (idx_reg)
                3'd0:    byte_next = head_job.raw0;
                3'd1:    byte_next = head_job.raw1;
                default: byte_next = head_job.raw2;
            endcase
        end
        else if (idx_reg < len0)
            byte_next = enc_byte(head_job.cp0, len0, idx_reg);
        else
            byte_next = enc_byte(head_job.cp1, len1, idx_reg - len0);
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            bvalid_reg <= bvalid_next;
            last_reg   <= last_next;
            end_reg    <= end_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bvalid_reg;
    assign run_last   = last_reg;
    assign text_end   = end_reg;

endmodule

>>> design/bom_sniffing_utf16le_to_utf8.sv
// BOM-sniffing UTF-16LE to UTF-8 transcoder, top level.
// Instantiates bsu_front, bsu_queue and bsu_back; depends on bsu_pkg.
//
// Input channel (in_valid/in_ready): one raw text byte per item, with
// final_byte marking the last byte of a text. A leading FF FE switches to
// UTF-16LE decoding, a leading EF BB BF is stripped, anything else passes.
// Output channel (out_valid/out_ready): one UTF-8 byte per item; run_last
// flags the last byte caused by an input byte, text_end the last of a text,
// and byte_valid is low only on a bare end marker.
// An input byte that yields output is written into the job queue when
// accepted, and its first output item then goes through the output
// register to the ports. Each accepted byte yields 0 to 6 output items,
// and the back emits one item per cycle while out_ready is high, so the
// input takes one byte per cycle when each byte yields at most one item.
// The two-entry job queue lets the front keep accepting while the
// back walks a job.
// Reset clears the sniffing state, the queue and the output valid flag.
// When out_ready is low the output holds; once the queue fills, in_ready
// drops until the back drains a job.
module bom_sniffing_utf16le_to_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       text_end
);
    import bsu_pkg::*;

    bsu_job_t   push_job, head_job;
    bsu_qstat_t qstat;
    logic       push, pop;

    // Sniffing and unit pairing
    bsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .qstat      (qstat),
        .push       (push),
        .job        (push_job)
    );

    // Job queue
    bsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    // Byte emission
    bsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .text_end   (text_end)
    );

endmodule

>>> design/bsu_checker.sv
// Port-level checker for the transcoder, bound to the top level.
// Depends on bom_sniffing_utf16le_to_utf8_assert.svh.
`include "bom_sniffing_utf16le_to_utf8_assert.svh"

module bsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       run_last,
    input logic       text_end
);

    // A stalled output item holds
    `BSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte), "stalled output changed")

    // A bare end marker closes both the run and the text
    `BSU_ASSERT_IMPLY(a_marker_ends, out_valid && !byte_valid, run_last && text_end, "bare marker not final")

    // A bare end marker carries a zero byte
    `BSU_ASSERT_IMPLY(a_marker_zero, out_valid && !byte_valid, out_byte == 8'h00, "bare marker byte not zero")

    // The end of a text is also the end of its input byte's run
    `BSU_ASSERT_IMPLY(a_end_in_run, out_valid && text_end, run_last, "text end without run end")

endmodule

bind bom_sniffing_utf16le_to_utf8 bsu_checker u_bsu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_end   (text_end)
);

>>> dv/tb_bom_sniffing_utf16le_to_utf8.sv
// Self-checking testbench for the BOM-sniffing UTF-16LE to UTF-8 transcoder.
// Predicts every output item from the input byte stream and compares in order.
// Depends on bsu_pkg and bom_sniffing_utf16le_to_utf8.
module tb_bom_sniffing_utf16le_to_utf8;
    import bsu_pkg::*;

    typedef logic [7:0] text_q_t[$];

    // Sniffer phases as the predictor tracks them
    typedef enum logic [2:0] {
        PH_START,
        PH_FF_HELD,
        PH_EF_HELD,
        PH_EFBB_HELD,
        PH_PASS,
        PH_UTF16
    } sniff_phase_e;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_CADENCE
    } ready_mode_e;

    // One output item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
    } utf8_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;

    // Predictor state
    sniff_phase_e sniff_ph = PH_START;
    logic [7:0]   unit_lo = 8'h00;
    logic         unit_lo_v = 1'b0;
    logic [15:0]  held_high = 16'h0000;
    logic         held_high_v = 1'b0;

    logic [7:0] step_bytes[$];
    utf8_item_t utf8_expected[$];

    int          err_count = 0;
    int          burst_left = 0;
    int unsigned stall_tick = 0;
    ready_mode_e ready_mode = RDY_ALWAYS;

    bom_sniffing_utf16le_to_utf8 u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .text_end   (text_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // At most six bytes per input byte
    function automatic void push_byte(input logic [7:0] b);
        if (step_bytes.size() < 6)
            step_bytes = {step_bytes, b};
    endfunction

    function automatic void push_cp(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            push_byte(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            push_byte({3'b110, cp[10:6]});
            push_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            push_byte({4'b1110, cp[15:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end
        else
        begin
            push_byte({5'b11110, cp[20:18]});
            push_byte({2'b10, cp[17:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Advance the predictor by one input byte and queue what it yields
    function automatic void transcode_byte(input logic [7:0] b, input logic fin);
        logic [15:0] unit;
        logic        joined;
        utf8_item_t  it;
        step_bytes.delete();
        case (sniff_ph)
            PH_START:
            begin
                if (!fin && b == BOM16_B0)
                    sniff_ph = PH_FF_HELD;
                else if (!fin && b == BOM8_B0)
                    sniff_ph = PH_EF_HELD;
                else
                begin
                    push_byte(b);
                    sniff_ph = PH_PASS;
                end
            end
            PH_FF_HELD:
            begin
                if (b == BOM16_B1)
                    sniff_ph = PH_UTF16;
                else
                begin
                    push_byte(BOM16_B0);
                    push_byte(b);
                    sniff_ph = PH_PASS;
                end
            end
            PH_EF_HELD:
            begin
                if (b == BOM8_B1 && !fin)
                    sniff_ph = PH_EFBB_HELD;
                else
                begin
                    push_byte(BOM8_B0);
                    push_byte(b);
                    sniff_ph = PH_PASS;
                end
            end
            PH_EFBB_HELD:
            begin
                if (b != BOM8_B2)
                begin
                    push_byte(BOM8_B0);
                    push_byte(BOM8_B1);
                    push_byte(b);
                end
                sniff_ph = PH_PASS;
            end
            PH_UTF16:
            begin
                if (!unit_lo_v)
                begin
                    unit_lo   = b;
                    unit_lo_v = 1'b1;
                    // odd trailing byte: flush a waiting high surrogate
                    if (fin && held_high_v)
                    begin
                        push_cp({5'd0, held_high});
                        held_high_v = 1'b0;
                    end
                end
                else
                begin
                    unit      = {b, unit_lo};
                    unit_lo_v = 1'b0;
                    joined    = 1'b0;
                    if (held_high_v)
                    begin
                        held_high_v = 1'b0;
                        if (unit[15:10] == SURR_LOW)
                        begin
                            push_cp(SUPP_BASE + {1'b0, held_high[9:0], unit[9:0]});
                            joined = 1'b1;
                        end
                        else
                            push_cp({5'd0, held_high});
                    end
                    if (!joined)
                    begin
                        if (unit[15:10] == SURR_HIGH && !fin)
                        begin
                            held_high   = unit;
                            held_high_v = 1'b1;
                        end
                        else
                            push_cp({5'd0, unit});
                    end
                end
            end
            default:
            begin
                push_byte(b);
                sniff_ph = PH_PASS;
            end
        endcase

        if (fin)
        begin
            sniff_ph    = PH_START;
            unit_lo     = 8'h00;
            unit_lo_v   = 1'b0;
            held_high   = 16'h0000;
            held_high_v = 1'b0;
            // nothing left to emit: bare end marker
            if (step_bytes.size() == 0)
            begin
                it = '{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b1, text_end: 1'b1};
                utf8_expected = {utf8_expected, it};
            end
        end

        foreach (step_bytes[k])
        begin
            it.out_byte   = step_bytes[k];
            it.byte_valid = 1'b1;
            it.run_last   = (k == step_bytes.size() - 1);
            it.text_end   = fin && (k == step_bytes.size() - 1);
            utf8_expected = {utf8_expected, it};
        end
    endfunction

    // Sender gaps: bursts of random length, sometimes long ones
    task automatic sender_idle();
        int gap;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
        else
            burst_left--;
    endtask

    // Offer one item and hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic fin);
        in_valid   <= 1'b1;
        in_byte    <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        transcode_byte(b, fin);
        sender_idle();
    endtask

    task automatic send_text(input text_q_t text);
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    // Short texts, most of them ending inside or just after a mark
    task automatic test_short_texts();
        send_text('{8'h00});
        send_text('{BOM16_B0});
        send_text('{BOM8_B0, BOM8_B1});
        send_text('{BOM16_B0, 8'h41});
        send_text('{BOM8_B0, BOM8_B1, BOM8_B2});
        send_text('{BOM16_B0, BOM16_B1, 8'h41});
    endtask

    // One UTF-16LE text covering every encoded length and surrogate case
    task automatic test_utf16_units();
        send_text('{BOM16_B0, BOM16_B1,
                    8'h7F, 8'h00,              // one byte
                    8'hFF, 8'h07,              // two bytes
                    8'hFF, 8'hFF,              // three bytes
                    8'hFF, 8'hDB, 8'hFF, 8'hDF, // highest pair
                    8'hFF, 8'hDB, 8'h41, 8'h00, // high then plain unit
                    8'h00, 8'hDC,              // lone low
                    8'h00, 8'hD8, 8'h7F});     // pending high, odd end
    endtask

    function automatic logic [15:0] random_unit();
        logic [15:0] u;
        case ($urandom_range(0, 4))
            0:       u = 16'($urandom_range(16'h0000, 16'h007F));
            1:       u = 16'($urandom_range(16'h0080, 16'h07FF));
            2:       u = 16'($urandom_range(16'h0800, 16'hFFFF));
            3:       u = 16'($urandom_range(16'hD800, 16'hDFFF));
            default: u = 16'($urandom_range(16'h0000, 16'hFFFF));
        endcase
        return u;
    endfunction

    // Mostly UTF-16LE texts, not all well-formed; the rest UTF-8 marks, broken marks and noise
    task automatic test_random_texts();
        text_q_t     text;
        int          sent;
        int          units;
        logic [15:0] u;
        logic [15:0] lo_u;
        sent = 0;
        while (sent < 200)
        begin
            text.delete();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    text = {text, BOM16_B0, BOM16_B1};
                    units = $urandom_range(1, 6);
                    repeat (units)
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            u    = 16'($urandom_range(16'hD800, 16'hDBFF));
                            lo_u = 16'($urandom_range(16'hDC00, 16'hDFFF));
                            text = {text, u[7:0], u[15:8], lo_u[7:0], lo_u[15:8]};
                        end
                        else
                        begin
                            u = random_unit();
                            text = {text, u[7:0], u[15:8]};
                        end
                    end
                    if ($urandom_range(0, 3) == 0)
                        text = {text, 8'($urandom_range(0, 255))};
                end
                6:
                begin
                    text = {text, BOM8_B0, BOM8_B1, BOM8_B2};
                    repeat ($urandom_range(0, 4))
                        text = {text, 8'($urandom_range(0, 255))};
                end
                7:
                begin
                    // broken or truncated mark
                    case ($urandom_range(0, 2))
                        0: text = {text, BOM16_B0};
                        1: text = {text, BOM8_B0};
                        default:
                        begin
                            text = {text, BOM8_B0, BOM8_B1};
                        end
                    endcase
                    repeat ($urandom_range(0, 3))
                        text = {text, 8'($urandom_range(0, 255))};
                end
                default:
                begin
                    repeat ($urandom_range(1, 6))
                        text = {text, 8'($urandom_range(0, 255))};
                end
            endcase
            send_text(text);
            sent += text.size();
        end
    endtask

    // Result checker and receiver stall pattern
    always @(posedge clk)
    begin : out_check
        utf8_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (utf8_expected.size() == 0)
            begin
                $error("unexpected item: out_byte %h byte_valid %b run_last %b text_end %b",
                       out_byte, byte_valid, run_last, text_end);
                err_count++;
            end
            else
            begin
                want = utf8_expected.pop_front();
                if (out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, out_byte);
                    err_count++;
                end
                if (byte_valid !== want.byte_valid)
                begin
                    $error("byte_valid: expected %b, got %b", want.byte_valid, byte_valid);
                    err_count++;
                end
                if (run_last !== want.run_last)
                begin
                    $error("run_last: expected %b, got %b", want.run_last, run_last);
                    err_count++;
                end
                if (text_end !== want.text_end)
                begin
                    $error("text_end: expected %b, got %b", want.text_end, text_end);
                    err_count++;
                end
            end
        end

        stall_tick <= stall_tick + 1;
        if (stall_tick[5:0] == 6'd0)
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
        case (ready_mode)
            RDY_ALWAYS: out_ready <= 1'b1;
            RDY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
            RDY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:    out_ready <= (stall_tick[2:0] < 3'd5);
        endcase
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_texts();
        test_utf16_units();
        test_random_texts();
        in_valid   <= 1'b0;
        final_byte <= 1'b0;

        // drain, then a short settle window
        while (utf8_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
